FILE: hw/rtl/tgi_pkg.sv
// Shared types and constants for the trilinear grid interpolator.
`timescale 1ns / 1ps
`default_nettype none
package tgi_pkg;

    localparam int NODE_W  = 4;
    localparam int FIELD_AW = 3 * NODE_W;
    localparam int FRAC_W  = 17;

    localparam logic [2:0] KIND_LD_X   = 3'd0;
    localparam logic [2:0] KIND_LD_Y   = 3'd1;
    localparam logic [2:0] KIND_LD_Z   = 3'd2;
    localparam logic [2:0] KIND_LD_F   = 3'd3;
    localparam logic [2:0] KIND_QUERY  = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic [NODE_W-1:0]  node_x;
        logic [NODE_W-1:0]  node_y;
        logic [NODE_W-1:0]  node_z;
        logic signed [31:0] load_word;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } item_t;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic               in_range;
    } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tgi_frac.sv
// Cell fraction unit: clamp(num * 2^16 / den, 0, 1.0), restoring, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tgi_frac
    import tgi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [32:0]  num,
    input  wire logic signed [32:0]  den,
    output logic                     done,
    output logic [FRAC_W-1:0]        frac
);

    logic              busy_reg;
    logic [3:0]        step_reg;
    logic [33:0]       rem_reg;
    logic [33:0]       den_reg;
    logic [15:0]       q_reg;
    logic              done_reg;
    logic [FRAC_W-1:0] frac_reg;

    logic [33:0] r2;
    logic        ge;
    logic [15:0] q_next;

    always_comb
    begin
        r2     = {rem_reg[32:0], 1'b0};
        ge     = (r2 >= den_reg);
        q_next = {q_reg[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                q_reg    <= '0;
                rem_reg  <= 34'(num);
                den_reg  <= 34'(den);
                if (den <= 0 || num <= 0)
                begin
                    frac_reg <= '0;
                    done_reg <= 1'b1;
                end
                else if (num >= den)
                begin
                    frac_reg <= FRAC_W'(1 << 16);
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? (r2 - den_reg) : r2;
                q_reg    <= q_next;
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    frac_reg <= {1'b0, q_next};
                end
            end
        end
    end

    assign done = done_reg;
    assign frac = frac_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/tgi_blend.sv
// Linear blend unit: a + floor((b - a) * t + 0.5), two-stage.
`timescale 1ns / 1ps
`default_nettype none
module tgi_blend
    import tgi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [31:0]  a,
    input  wire logic signed [31:0]  b,
    input  wire logic [FRAC_W-1:0]   t,
    output logic                     done,
    output logic signed [33:0]       res
);

    logic               v1_reg;
    logic               v2_reg;
    logic signed [50:0] prod_reg;
    logic signed [31:0] a_reg;
    logic signed [33:0] res_reg;

    logic signed [32:0] diff;
    logic signed [50:0] rnd;
    logic signed [51:0] sum;

    always_comb
    begin
        diff = 33'(b) - 33'(a);
        rnd  = prod_reg + 51'sd32768;
        sum  = 52'(a_reg) + 52'(rnd >>> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            if (start)
            begin
                prod_reg <= 51'(diff * $signed({1'b0, t}));
                a_reg    <= a;
            end
            if (v1_reg)
            begin
                res_reg <= sum[33:0];
            end
        end
    end

    assign done = v2_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/trilinear_grid_interpolator_core.sv
// Top level of the trilinear grid interpolator: sequencer, coordinate and field stores.
//
// Usage: one input channel (item_valid / item_stall / item) and one result
// channel (result_valid / result_stall / result). A beat with kind 0..2
// writes a coordinate (ignored if the node index is not below the axis
// size), kind 3 writes a field node, kind 4 is a query, kinds 5..7 are
// dropped. Loads and dropped beats never stall the input and give no result.
// A query gives exactly one result beat: the trilinear value, or zero with
// in_range low when the point falls outside the grid cells.
// A query does, per axis, a linear scan of the coordinate store (one
// store read per cycle), a fetch of the cell bounds (S_C0, S_C1, S_C2)
// and a division in the shared fraction divider (16 steps unless the
// fraction clamps); then reads of the eight field corners and 7 passes
// of the shared blend multiplier, and S_DONE posts the result. Through
// all of this item_stall stays high. The result sits in an output
// register: a stalled result holds; a finished query waits for the slot
// before item_stall drops.
// Reset clears control only; the stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module trilinear_grid_interpolator_core
    import tgi_pkg::*;
#(
    parameter int X_POINTS = 16,
    parameter int Y_POINTS = 16,
    parameter int Z_POINTS = 16
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire item_t   item,
    output logic         result_valid,
    input  wire logic    result_stall,
    output result_t      result
);

    localparam int XW = $clog2(X_POINTS);
    localparam int YW = $clog2(Y_POINTS);
    localparam int ZW = $clog2(Z_POINTS);
    localparam int IW = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
    localparam logic [IW-1:0] XLAST = IW'(X_POINTS - 1);
    localparam logic [IW-1:0] YLAST = IW'(Y_POINTS - 1);
    localparam logic [IW-1:0] ZLAST = IW'(Z_POINTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SDRAIN, S_C0, S_C1, S_C2, S_DIV,
        S_FRD, S_FDRAIN, S_BLEND, S_BWAIT, S_DONE
    } state_t;

    state_t state_reg;
    logic [1:0]         axis_reg;
    logic [IW-1:0]      cnt_reg;
    logic               sv_reg;
    logic [IW-1:0]      sidx_reg;
    logic               found_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      ix_reg, iy_reg, iz_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [31:0] c0_reg;
    logic [FRAC_W-1:0]  tx_reg, ty_reg, tz_reg;
    logic [2:0]         fcnt_reg;
    logic               fv_reg;
    logic [2:0]         fidx_reg;
    logic signed [31:0] w_reg [8];
    logic [3:0]         wlen_reg;
    result_t            pend_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    // stores, registered read
    logic signed [31:0] x_mem [X_POINTS];
    logic signed [31:0] y_mem [Y_POINTS];
    logic signed [31:0] z_mem [Z_POINTS];
    logic signed [31:0] f_mem [2**FIELD_AW];
    logic signed [31:0] xr_reg, yr_reg, zr_reg, fd_reg;

    logic               acc;
    logic [IW-1:0]      rd_addr;
    logic [FIELD_AW-1:0] faddr;
    logic signed [31:0] psel, rsel;
    logic [IW-1:0]      lastsel;
    logic               hit, found_now;
    logic [IW-1:0]      idx_now;
    logic               div_start, div_done;
    logic [FRAC_W-1:0]  div_frac;
    logic signed [32:0] div_num, div_den;
    logic               bl_start, bl_done;
    logic signed [33:0] bl_res;
    logic [FRAC_W-1:0]  tsel;
    logic signed [31:0] sat;
    logic [2:0]         wpos;

    assign acc = item_valid && !item_stall;

    always_comb
    begin
        unique case (state_reg)
            S_C0:    rd_addr = idx_reg;
            S_C1:    rd_addr = idx_reg + IW'(1);
            default: rd_addr = cnt_reg;
        endcase
        faddr = {NODE_W'({1'b0, ix_reg} + (IW+1)'(fcnt_reg[0])),
                 NODE_W'({1'b0, iy_reg} + (IW+1)'(fcnt_reg[1])),
                 NODE_W'({1'b0, iz_reg} + (IW+1)'(fcnt_reg[2]))};
        unique case (axis_reg)
            2'd0:    begin psel = px_reg; rsel = xr_reg; lastsel = XLAST; end
            2'd1:    begin psel = py_reg; rsel = yr_reg; lastsel = YLAST; end
            default: begin psel = pz_reg; rsel = zr_reg; lastsel = ZLAST; end
        endcase
        hit       = sv_reg && (rsel <= psel);
        found_now = found_reg || hit;
        idx_now   = hit ? sidx_reg : idx_reg;
        div_start = (state_reg == S_C2);
        div_num   = 33'(psel) - 33'(c0_reg);
        div_den   = 33'(rsel) - 33'(c0_reg);
        bl_start  = (state_reg == S_BLEND);
        if (fcnt_reg < 3'd4)
            tsel = tx_reg;
        else if (fcnt_reg < 3'd6)
            tsel = ty_reg;
        else
            tsel = tz_reg;
        if (bl_res > 34'sd2147483647)
            sat = 32'sh7fffffff;
        else if (bl_res < -34'sd2147483648)
            sat = 32'sh80000000;
        else
            sat = bl_res[31:0];
        wpos = 3'(wlen_reg - 4'd2);
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.kind == KIND_LD_X && {5'd0, item.node_x} < 9'(X_POINTS))
            x_mem[XW'(item.node_x)] <= item.load_word;
        xr_reg <= x_mem[rd_addr[XW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.kind == KIND_LD_Y && {5'd0, item.node_y} < 9'(Y_POINTS))
            y_mem[YW'(item.node_y)] <= item.load_word;
        yr_reg <= y_mem[rd_addr[YW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.kind == KIND_LD_Z && {5'd0, item.node_z} < 9'(Z_POINTS))
            z_mem[ZW'(item.node_z)] <= item.load_word;
        zr_reg <= z_mem[rd_addr[ZW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (acc && item.kind == KIND_LD_F)
            f_mem[{item.node_x, item.node_y, item.node_z}] <= item.load_word;
        fd_reg <= f_mem[faddr];
    end

    tgi_frac u_frac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .frac  (div_frac)
    );

    tgi_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bl_start),
        .a     (w_reg[0]),
        .b     (w_reg[1]),
        .t     (tsel),
        .done  (bl_done),
        .res   (bl_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sv_reg        <= 1'b0;
            fv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // slot empties on a taken beat unless S_DONE refills it this cycle
            if (out_valid_reg && !result_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            if (fv_reg)
                w_reg[fidx_reg] <= fd_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (acc && item.kind == KIND_QUERY)
                    begin
                        px_reg    <= item.point_x;
                        py_reg    <= item.point_y;
                        pz_reg    <= item.point_z;
                        axis_reg  <= 2'd0;
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    sv_reg    <= 1'b1;
                    sidx_reg  <= cnt_reg;
                    found_reg <= found_now;
                    idx_reg   <= idx_now;
                    if (cnt_reg == lastsel)
                        state_reg <= S_SDRAIN;
                    else
                        cnt_reg <= cnt_reg + IW'(1);
                end
                S_SDRAIN:
                begin
                    sv_reg  <= 1'b0;
                    idx_reg <= idx_now;
                    if (!found_now || idx_now == lastsel)
                    begin
                        pend_reg  <= '{interpolated_value: '0, in_range: 1'b0};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        unique case (axis_reg)
                            2'd0:    ix_reg <= idx_now;
                            2'd1:    iy_reg <= idx_now;
                            default: iz_reg <= idx_now;
                        endcase
                        state_reg <= S_C0;
                    end
                end
                S_C0: state_reg <= S_C1;
                S_C1:
                begin
                    c0_reg    <= rsel;
                    state_reg <= S_C2;
                end
                S_C2: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        unique case (axis_reg)
                            2'd0:    tx_reg <= div_frac;
                            2'd1:    ty_reg <= div_frac;
                            default: tz_reg <= div_frac;
                        endcase
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                        fcnt_reg  <= '0;
                        if (axis_reg == 2'd2)
                            state_reg <= S_FRD;
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_FRD:
                begin
                    fv_reg   <= 1'b1;
                    fidx_reg <= fcnt_reg;
                    fcnt_reg <= fcnt_reg + 3'd1;
                    if (fcnt_reg == 3'd7)
                        state_reg <= S_FDRAIN;
                end
                S_FDRAIN:
                begin
                    fv_reg    <= 1'b0;
                    wlen_reg  <= 4'd8;
                    state_reg <= S_BLEND;
                end
                S_BLEND: state_reg <= S_BWAIT;
                S_BWAIT:
                begin
                    if (bl_done)
                    begin
                        // pop the two operands, push the blend at the tail
                        for (int k = 0; k < 6; k++)
                            w_reg[k] <= w_reg[k + 2];
                        w_reg[wpos] <= bl_res[31:0];
                        wlen_reg    <= wlen_reg - 4'd1;
                        fcnt_reg    <= fcnt_reg + 3'd1;
                        if (fcnt_reg == 3'd6)
                        begin
                            pend_reg  <= '{interpolated_value: sat, in_range: 1'b1};
                            state_reg <= S_DONE;
                        end
                        else
                            state_reg <= S_BLEND;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !result_stall)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/tgi_checker.sv
// Port-level checker for the trilinear grid interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tgi_checker
    import tgi_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    logic ld_acc;
    assign ld_acc = item_valid && !item_stall &&
        (item.kind == KIND_LD_X || item.kind == KIND_LD_Y ||
         item.kind == KIND_LD_Z || item.kind == KIND_LD_F);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("stalled result changed");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.kind == KIND_QUERY |=> item_stall)
        else $error("query did not hold off the input");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        ld_acc |=> !item_stall)
        else $error("load beat stalled the input");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.in_range |-> result.interpolated_value == 0)
        else $error("out-of-grid result not zero");

endmodule

bind trilinear_grid_interpolator_core tgi_checker u_tgi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire

FILE: tb/tb.sv
// Testbench for trilinear_grid_interpolator_core: grid loads, queries, self-checking results.
`timescale 1ns / 1ps

module tb;
    import tgi_pkg::*;

    // kinds above the query code are dropped by the block
    localparam logic [2:0] KIND_DROP_LO = 3'd5;
    localparam logic [2:0] KIND_DROP_HI = 3'd7;
    localparam int         AXIS_N       = 16;
    localparam int         ITEM_GOAL    = 1450;
    localparam longint     CYCLE_LIMIT  = 2000000;

    // Scoreboard: private copy of the grid, trilinear predictor, queue of due results.
    class grid_scoreboard;
        int      xc[AXIS_N];
        int      yc[AXIS_N];
        int      zc[AXIS_N];
        int      fld[4096];
        bit      fw[4096];
        result_t due[$];
        int      errs;
        int      n_query;
        int      n_inside;
        int      n_checked;

        function int node_addr(int x, int y, int z);
            return (x << 8) | (y << 4) | z;
        endfunction

        // largest index whose coordinate is at or below p (scans all, tolerates unsorted)
        function int find_cell(int c[AXIS_N], longint p);
            int r;
            r = -1;
            for (int n = 0; n < AXIS_N; n++)
                if (longint'(c[n]) <= p)
                    r = n;
            return r;
        endfunction

        // Q1.16 cell fraction, truncated then clamped to [0, 1]
        function longint cell_frac(longint num, longint den);
            longint q;
            if (den == 0)
                return 0;
            q = (num * 65536) / den;
            if (q < 0)
                q = 0;
            if (q > 65536)
                q = 65536;
            return q;
        endfunction

        // a + (b - a) * t, rounded to nearest, ties up
        function longint lerp(longint a, longint b, longint t);
            longint d;
            d = (b - a) * t + 32768;
            return a + (d >>> 16);
        endfunction

        function longint corner(int x, int y, int z);
            return longint'(fld[node_addr(x, y, z)]);
        endfunction

        function bit locate_all(item_t it, output int i, output int j, output int k);
            i = find_cell(xc, longint'(it.point_x));
            j = find_cell(yc, longint'(it.point_y));
            k = find_cell(zc, longint'(it.point_z));
            return !(i < 0 || j < 0 || k < 0 ||
                     i + 2 > AXIS_N || j + 2 > AXIS_N || k + 2 > AXIS_N);
        endfunction

        // true when the query would read only field nodes already loaded
        function bit corners_loaded(item_t it);
            int i, j, k;
            if (!locate_all(it, i, j, k))
                return 1;
            for (int d = 0; d < 8; d++)
                if (!fw[node_addr(i + d[0], j + d[1], k + d[2])])
                    return 0;
            return 1;
        endfunction

        function result_t interpolate(item_t it);
            result_t r;
            int      i, j, k;
            longint  tx, ty, tz, f00, f10, f01, f11, g0, g1, v;
            r = '0;
            if (!locate_all(it, i, j, k))
                return r;
            tx = cell_frac(longint'(it.point_x) - xc[i], longint'(xc[i + 1]) - xc[i]);
            ty = cell_frac(longint'(it.point_y) - yc[j], longint'(yc[j + 1]) - yc[j]);
            tz = cell_frac(longint'(it.point_z) - zc[k], longint'(zc[k + 1]) - zc[k]);
            f00 = lerp(corner(i, j, k),         corner(i + 1, j, k),         tx);
            f10 = lerp(corner(i, j + 1, k),     corner(i + 1, j + 1, k),     tx);
            f01 = lerp(corner(i, j, k + 1),     corner(i + 1, j, k + 1),     tx);
            f11 = lerp(corner(i, j + 1, k + 1), corner(i + 1, j + 1, k + 1), tx);
            g0 = lerp(f00, f10, ty);
            g1 = lerp(f01, f11, ty);
            v  = lerp(g0, g1, tz);
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            if (v < -64'sd2147483648)
                v = -64'sd2147483648;
            r.interpolated_value = v[31:0];
            r.in_range = 1'b1;
            return r;
        endfunction

        // accepted input beat: update grid copy or queue the expected answer
        function void note_item(item_t it);
            result_t r;
            case (it.kind)
                KIND_LD_X: xc[it.node_x] = it.load_word;
                KIND_LD_Y: yc[it.node_y] = it.load_word;
                KIND_LD_Z: zc[it.node_z] = it.load_word;
                KIND_LD_F:
                begin
                    fld[node_addr(it.node_x, it.node_y, it.node_z)] = it.load_word;
                    fw[node_addr(it.node_x, it.node_y, it.node_z)]  = 1'b1;
                end
                KIND_QUERY:
                begin
                    r = interpolate(it);
                    due.push_back(r);
                    n_query++;
                    if (r.in_range)
                        n_inside++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                $error("result beat with nothing due: value %0d in_range %0b",
                       got.interpolated_value, got.in_range);
                errs++;
                return;
            end
            want = due.pop_front();
            n_checked++;
            if (got.interpolated_value !== want.interpolated_value)
            begin
                $error("interpolated_value: expected %0d, got %0d",
                       want.interpolated_value, got.interpolated_value);
                errs++;
            end
            if (got.in_range !== want.in_range)
            begin
                $error("in_range: expected %0b, got %0b", want.in_range, got.in_range);
                errs++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    grid_scoreboard sb;
    int     sent;
    bit     quiet;       // no idling on either side in the closing stretch
    int     hold_req;    // long receiver hold-off request, in cycles
    longint cycles = 0;

    trilinear_grid_interpolator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // cycle guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, sb.due.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result side: check accepted beats, then pick next cycle's stall.
    initial
    begin : result_side
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                sb.check_result(result);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (quiet)
                result_stall <= 1'b0;
            else if (burst_left > 0)
            begin
                burst_left--;
                result_stall <= 1'b1;
            end
            else if ($urandom_range(3) == 0)
            begin
                burst_left = $urandom_range(9, 1) - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // One beat on the input channel; valid stays up across back-to-back beats.
    task automatic send_beat(item_t it);
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_item(it);
        sent++;
        if (!quiet && $urandom_range(3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
    endtask

    function automatic int rand_word();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic item_t rand_item();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return item_t'(bits[$bits(item_t)-1:0]);
    endfunction

    task automatic load_coord(logic [2:0] k, int n, int w);
        item_t it;
        it        = rand_item();
        it.kind   = k;
        it.node_x = NODE_W'(n);
        it.node_y = NODE_W'(n);
        it.node_z = NODE_W'(n);
        it.load_word = w;
        send_beat(it);
    endtask

    task automatic load_node(int x, int y, int z, int w);
        item_t it;
        it        = rand_item();
        it.kind   = KIND_LD_F;
        it.node_x = NODE_W'(x);
        it.node_y = NODE_W'(y);
        it.node_z = NODE_W'(z);
        it.load_word = w;
        send_beat(it);
    endtask

    // New coordinate list: sorted spread, extremes, repeated nodes or unsorted.
    task automatic reload_axis(logic [2:0] k);
        int vals[$];
        int mode;
        mode = $urandom_range(4);
        for (int n = 0; n < AXIS_N; n++)
            vals.push_back(mode == 1 ? $urandom : ($urandom_range(32'h0040_0000) - 32'h0020_0000));
        if (mode == 2)
        begin
            vals[0] = 32'sh8000_0000;
            vals[AXIS_N-1] = 32'sh7fff_ffff;
        end
        if (mode != 3)
            vals.sort();
        if (mode == 4)
            for (int n = 1; n < AXIS_N; n += 3)
                vals[n] = vals[n-1];    // zero-width cells
        if (mode == 4)
            vals.sort();
        for (int n = 0; n < AXIS_N; n++)
            load_coord(k, n, vals[n]);
    endtask

    function automatic int point_in(int c[AXIS_N], int n);
        longint w;
        longint u;
        w = longint'(c[n+1]) - c[n];
        if (w <= 0)
            return c[n];
        u = {$urandom, $urandom};
        if (u < 0)
            u = -u;
        return int'(longint'(c[n]) + u % (w + 1));
    endfunction

    // aimed or random query whose corners are all loaded, else one that lands outside
    task automatic send_query(bit aim);
        item_t it;
        bit    ok;
        ok = 0;
        it = rand_item();
        it.kind = KIND_QUERY;
        for (int tries = 0; tries < 30 && !ok; tries++)
        begin
            if (aim)
            begin
                it.point_x = point_in(sb.xc, $urandom_range(AXIS_N - 2));
                it.point_y = point_in(sb.yc, $urandom_range(AXIS_N - 2));
                it.point_z = point_in(sb.zc, $urandom_range(AXIS_N - 2));
            end
            else
            begin
                it.point_x = rand_word();
                it.point_y = rand_word();
                it.point_z = rand_word();
            end
            ok = sb.corners_loaded(it);
        end
        if (!ok)
            it.point_x = sb.xc[AXIS_N-1];   // on the last node: always outside
        send_beat(it);
    endtask

    // load a small block of field nodes so queries can land in its cells
    task automatic load_block();
        int bx, by, bz, sz;
        sz = $urandom_range(3, 2);
        bx = $urandom_range(AXIS_N - sz);
        by = $urandom_range(AXIS_N - sz);
        bz = $urandom_range(AXIS_N - sz);
        for (int x = bx; x < bx + sz; x++)
            for (int y = by; y < by + sz; y++)
                for (int z = bz; z < bz + sz; z++)
                    load_node(x, y, z, rand_word());
    endtask

    initial
    begin : stimulus
        item_t it;
        int    ph;
        sb           = new();
        sent         = 0;
        quiet        = 0;
        hold_req     = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme coordinate lists, extreme field corners, an edge query, dropped kinds.
        for (int n = 0; n < AXIS_N; n++)
        begin
            load_coord(KIND_LD_X, n, n == 0 ? 32'sh8000_0000 :
                       n == AXIS_N-1 ? 32'sh7fff_ffff : (n - 8) <<< 16);
            load_coord(KIND_LD_Y, n, n << 16);
            load_coord(KIND_LD_Z, n, n == 5 ? 6 << 16 : n << 16);   // nodes 5 and 6 coincide
        end
        load_node(0, 0, 0, 32'sh8000_0000);
        load_node(1, 0, 0, 32'sh7fff_ffff);
        for (int d = 0; d < 8; d++)
            load_node(d[0], d[1], d[2], d == 7 ? 32'sh7fff_ffff : 32'sh8000_0000);
        for (int d = 0; d < 8; d++)
            load_node(14 + d[0], 5 + d[1], 5 + d[2], d << 20);
        // wide first x cell, fraction just under one, extreme corners
        it = '0;
        it.kind    = KIND_QUERY;
        it.point_x = 32'shfff8_ffff;
        it.point_y = 32'sh0000_8000;
        it.point_z = 32'sh0000_4000;
        send_beat(it);
        for (int d = KIND_DROP_LO; d <= KIND_DROP_HI; d++)
        begin
            it = rand_item();
            it.kind = 3'(d);
            send_beat(it);
        end
        drain_results();

        // Random phases of loads and queries.
        ph = 0;
        while (sent < ITEM_GOAL)
        begin
            if (sent > ITEM_GOAL - 150)
                quiet = 1;
            if ($urandom_range(3) == 0)
                reload_axis(3'($urandom_range(KIND_LD_Z, KIND_LD_X)));
            load_block();
            repeat ($urandom_range(4))
                load_node($urandom_range(15), $urandom_range(15), $urandom_range(15), rand_word());
            if ($urandom_range(4) == 0)
            begin
                it = rand_item();
                it.kind = 3'($urandom_range(KIND_DROP_HI, KIND_DROP_LO));
                send_beat(it);
            end
            if (ph == 3)
                hold_req = 600;     // receiver backs off while queries keep coming
            repeat ($urandom_range(30, 10))
                send_query($urandom_range(9) != 0);
            if ($urandom_range(1) == 0)
                drain_results();
            ph++;
        end
        item_valid <= 1'b0;
        drain_results();
        repeat (300) @(posedge clk);

        $display("%0d beats sent, %0d queries (%0d inside the grid), %0d results checked",
                 sent, sb.n_query, sb.n_inside, sb.n_checked);
        $display("covered coordinate reloads incl. extremes, repeated and unsorted nodes");
        if (sb.errs == 0 && sb.due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tgi_pkg.sv
hw/rtl/tgi_frac.sv
hw/rtl/tgi_blend.sv
hw/rtl/trilinear_grid_interpolator_core.sv
hw/rtl/tgi_checker.sv
tb/tb.sv
